// File: rtl/core/pixel_to_axis_frame_transform_macros.svh
// assertion macros for the pixel to axis frame transform
`ifndef PIXEL_TO_AXIS_FRAME_TRANSFORM_MACROS_SVH
`define PIXEL_TO_AXIS_FRAME_TRANSFORM_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define P2A_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define P2A_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/p2a_pkg.sv
// shared constants for the pixel to axis frame transform
`default_nettype none

package p2a_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int PIXEL_BITS_DEF = 12;
    localparam int POS_W          = 32;
    localparam int REG_IDX_W      = 3;

    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AXES_READY   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_DX     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RIGHT_DY     = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SAT       = 2'd1;
    localparam logic [1:0] ST_ZERO_AXIS = 2'd2;

endpackage

`default_nettype wire

// File: rtl/core/p2a_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow check
`default_nettype none

module p2a_div #(
    parameter int NUM_W  = 28,
    parameter int DEN_W  = 13,
    parameter int QUO_W  = 17,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_vld,
    output logic [QUO_W-1:0]       quo,
    output logic                   ovf,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int CMP_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;

    logic [DEN_W-1:0]  rem_reg  [QUO_W];
    logic [QUO_W-1:0]  quo_reg  [QUO_W];
    logic [QUO_W-1:0]  lo_reg   [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic              ovf_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];
    logic [QUO_W-1:0]  vld_reg;

    logic [NUM_W-1:0] num_hi;

    assign num_hi = num >> QUO_W;

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [DEN_W-1:0]  rem_in;
        logic [QUO_W-1:0]  quo_in;
        logic [QUO_W-1:0]  lo_in;
        logic [DEN_W-1:0]  den_in;
        logic              ovf_in;
        logic [SIDE_W-1:0] side_k;
        logic              vld_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              ge;
        logic [DEN_W-1:0]  rem_next;
        logic [QUO_W-1:0]  quo_next;

        if (k == 0) begin : g_first
            assign rem_in = DEN_W'(num_hi);
            assign quo_in = '0;
            assign lo_in  = num[QUO_W-1:0];
            assign den_in = den;
            assign ovf_in = CMP_W'(num_hi) >= CMP_W'(den);
            assign side_k = side_in;
            assign vld_in = in_vld;
        end
        else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign lo_in  = lo_reg[k-1];
            assign den_in = den_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
            assign side_k = side_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        always_comb
        begin
            trial    = {rem_in, lo_in[QUO_W-1]};
            diff     = trial - {1'b0, den_in};
            ge       = trial >= {1'b0, den_in};
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_in[QUO_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                lo_reg[k]   <= lo_in << 1;
                den_reg[k]  <= den_in;
                ovf_reg[k]  <= ovf_in;
                side_reg[k] <= side_k;
            end
        end
    end

    assign out_vld  = vld_reg[QUO_W-1];
    assign quo      = quo_reg[QUO_W-1];
    assign ovf      = ovf_reg[QUO_W-1];
    assign side_out = side_reg[QUO_W-1];

endmodule

`default_nettype wire

// File: rtl/core/pixel_to_axis_frame_transform.sv
// top level: pixel coordinate to frame and user-axis coordinates, fully pipelined
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  input    | in_valid / in_ready    | pixel_x, pixel_y
//  output   | out_valid / out_ready  | frame_u, frame_v, axis_pos_x, axis_pos_y,
//           |                        | axis_applied, status
//  config   | cfg_we                 | cfg_index, cfg_wdata
//
//  one transfer per cycle in and out while the output is not stalled; the datapath runs
//  through the three bit-serial divider pipelines in series
//  a stall at the output freezes every stage at once; in_ready is low only then
//  reset clears valid bits and loads the configuration defaults
`default_nettype none

module pixel_to_axis_frame_transform #(
    parameter int FRAC_BITS  = p2a_pkg::FRAC_BITS_DEF,
    parameter int PIXEL_BITS = p2a_pkg::PIXEL_BITS_DEF,
    localparam int DIM_W     = PIXEL_BITS + 1,
    localparam int VEC_W     = FRAC_BITS + 2,
    localparam int FRM_W     = FRAC_BITS + 1,
    localparam int CFG_W     = (DIM_W > VEC_W) ? DIM_W : VEC_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [PIXEL_BITS-1:0]         pixel_x,
    input  wire logic [PIXEL_BITS-1:0]         pixel_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [FRM_W-1:0]                   frame_u,
    output logic [FRM_W-1:0]                   frame_v,
    output logic signed [p2a_pkg::POS_W-1:0]   axis_pos_x,
    output logic signed [p2a_pkg::POS_W-1:0]   axis_pos_y,
    output logic                               axis_applied,
    output logic [1:0]                         status,
    input  wire logic                          cfg_we,
    input  wire logic [p2a_pkg::REG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]              cfg_wdata
);

    `include "pixel_to_axis_frame_transform_macros.svh"

    localparam int ORG_W     = FRAC_BITS + 1;
    localparam int POS_W     = p2a_pkg::POS_W;
    localparam int UV_NUM_W  = PIXEL_BITS + FRAC_BITS;
    localparam int SC_NUM_W  = FRAC_BITS + PIXEL_BITS + 3;
    localparam int WS        = SC_NUM_W + 2;
    localparam int PR_W      = 2 * WS;
    localparam int SUM_W     = PR_W + 1;
    localparam int QD_NUM_W  = SUM_W + FRAC_BITS;
    localparam int QD_QUO_W  = POS_W + 1;
    localparam int UVS_W     = 2 * FRM_W + 1;
    localparam int CS_W      = UVS_W + 3;

    localparam logic [FRM_W-1:0]    ONE_Q    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [QD_QUO_W-1:0] LIM_POS  = {2'b00, {(POS_W-1){1'b1}}};
    localparam logic [QD_QUO_W-1:0] LIM_NEG  = {2'b01, {(POS_W-1){1'b0}}};

    // configuration
    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic             axes_ready_reg;
    logic [ORG_W-1:0] origin_x_reg;
    logic [ORG_W-1:0] origin_y_reg;
    logic [VEC_W-1:0] right_dx_reg;
    logic [VEC_W-1:0] right_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_W'(p2a_pkg::FRAME_WIDTH_RST);
            frame_height_reg <= DIM_W'(p2a_pkg::FRAME_HEIGHT_RST);
            axes_ready_reg   <= 1'b0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            right_dx_reg     <= {2'b01, {FRAC_BITS{1'b0}}};
            right_dy_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                p2a_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[DIM_W-1:0];
                p2a_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[DIM_W-1:0];
                p2a_pkg::REG_AXES_READY:   axes_ready_reg   <= cfg_wdata[0];
                p2a_pkg::REG_ORIGIN_X:     origin_x_reg     <= cfg_wdata[ORG_W-1:0];
                p2a_pkg::REG_ORIGIN_Y:     origin_y_reg     <= cfg_wdata[ORG_W-1:0];
                p2a_pkg::REG_RIGHT_DX:     right_dx_reg     <= cfg_wdata[VEC_W-1:0];
                p2a_pkg::REG_RIGHT_DY:     right_dy_reg     <= cfg_wdata[VEC_W-1:0];
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic             en;

    // zero frame size counts as one
    assign w_eff    = (frame_width_reg == '0) ? DIM_W'(1) : frame_width_reg;
    assign h_eff    = (frame_height_reg == '0) ? DIM_W'(1) : frame_height_reg;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // normalization dividers
    logic             ua_vld;
    logic [FRM_W-1:0] ua_q;
    logic [FRM_W-1:0] va_q;
    logic             ua_ovf;
    logic             va_ovf;

    p2a_div #(
        .NUM_W (UV_NUM_W),
        .DEN_W (DIM_W),
        .QUO_W (FRM_W),
        .SIDE_W(1)
    ) u_div_u (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (in_valid),
        .num     ({pixel_x, {FRAC_BITS{1'b0}}}),
        .den     (w_eff),
        .side_in (1'b0),
        .out_vld (ua_vld),
        .quo     (ua_q),
        .ovf     (ua_ovf),
        .side_out()
    );

    p2a_div #(
        .NUM_W (UV_NUM_W),
        .DEN_W (DIM_W),
        .QUO_W (FRM_W),
        .SIDE_W(1)
    ) u_div_v (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (in_valid),
        .num     ({pixel_y, {FRAC_BITS{1'b0}}}),
        .den     (h_eff),
        .side_in (1'b0),
        .out_vld (),
        .quo     (va_q),
        .ovf     (va_ovf),
        .side_out()
    );

    // saturate u and v
    logic             u_sat;
    logic             v_sat;
    logic             a_vld_reg;
    logic [FRM_W-1:0] a_u_reg;
    logic [FRM_W-1:0] a_v_reg;
    logic             a_sat_reg;

    assign u_sat = ua_ovf || (ua_q > ONE_Q);
    assign v_sat = va_ovf || (va_q > ONE_Q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= ua_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_u_reg   <= u_sat ? ONE_Q : ua_q;
            a_v_reg   <= v_sat ? ONE_Q : va_q;
            a_sat_reg <= u_sat || v_sat;
        end
    end

    // scale by frame height ahead of the width division
    logic [ORG_W:0]      oy_diff;
    logic                oy_neg;
    logic [ORG_W-1:0]    oy_mag;
    logic                ry_neg;
    logic [VEC_W-1:0]    ry_mag;
    logic [FRM_W-1:0]    py_mag;
    logic                m_vld_reg;
    logic [UVS_W-1:0]    m_uvs_reg;
    logic [SC_NUM_W-1:0] m_py_reg;
    logic [SC_NUM_W-1:0] m_oy_reg;
    logic                m_oy_neg_reg;
    logic [SC_NUM_W-1:0] m_ay_reg;
    logic                m_ry_neg_reg;

    always_comb
    begin
        oy_diff = {1'b0, ONE_Q} - {1'b0, origin_y_reg};
        oy_neg  = oy_diff[ORG_W];
        oy_mag  = oy_neg ? ORG_W'(-oy_diff) : oy_diff[ORG_W-1:0];
        ry_neg  = right_dy_reg[VEC_W-1];
        ry_mag  = ry_neg ? (-right_dy_reg) : right_dy_reg;
        py_mag  = ONE_Q - a_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_uvs_reg    <= {a_u_reg, a_v_reg, a_sat_reg};
            m_py_reg     <= SC_NUM_W'(py_mag) * SC_NUM_W'(h_eff);
            m_oy_reg     <= SC_NUM_W'(oy_mag) * SC_NUM_W'(h_eff);
            m_oy_neg_reg <= oy_neg;
            m_ay_reg     <= SC_NUM_W'(ry_mag) * SC_NUM_W'(h_eff);
            m_ry_neg_reg <= ry_neg;
        end
    end

    // aspect dividers
    logic                b_vld;
    logic [UVS_W-1:0]    b_uvs;
    logic [SC_NUM_W-1:0] b_py_q;
    logic [SC_NUM_W-1:0] b_oy_q;
    logic [SC_NUM_W-1:0] b_ay_q;
    logic                b_oy_neg;
    logic                b_ry_neg;

    p2a_div #(
        .NUM_W (SC_NUM_W),
        .DEN_W (DIM_W),
        .QUO_W (SC_NUM_W),
        .SIDE_W(UVS_W)
    ) u_div_py (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (m_vld_reg),
        .num     (m_py_reg),
        .den     (w_eff),
        .side_in (m_uvs_reg),
        .out_vld (b_vld),
        .quo     (b_py_q),
        .ovf     (),
        .side_out(b_uvs)
    );

    p2a_div #(
        .NUM_W (SC_NUM_W),
        .DEN_W (DIM_W),
        .QUO_W (SC_NUM_W),
        .SIDE_W(1)
    ) u_div_oy (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (m_vld_reg),
        .num     (m_oy_reg),
        .den     (w_eff),
        .side_in (m_oy_neg_reg),
        .out_vld (),
        .quo     (b_oy_q),
        .ovf     (),
        .side_out(b_oy_neg)
    );

    p2a_div #(
        .NUM_W (SC_NUM_W),
        .DEN_W (DIM_W),
        .QUO_W (SC_NUM_W),
        .SIDE_W(1)
    ) u_div_ay (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (m_vld_reg),
        .num     (m_ay_reg),
        .den     (w_eff),
        .side_in (m_ry_neg_reg),
        .out_vld (),
        .quo     (b_ay_q),
        .ovf     (),
        .side_out(b_ry_neg)
    );

    // signed vectors and point offset from origin
    logic signed [WS-1:0] py_s;
    logic signed [WS-1:0] oyq_s;
    logic signed [WS-1:0] ayq_s;
    logic signed [WS-1:0] oy_s;
    logic signed [WS-1:0] px_s;
    logic signed [WS-1:0] ox_s;
    logic                 d_vld_reg;
    logic [UVS_W-1:0]     d_uvs_reg;
    logic signed [WS-1:0] d_ax_reg;
    logic signed [WS-1:0] d_ay_reg;
    logic signed [WS-1:0] d_dx_reg;
    logic signed [WS-1:0] d_dy_reg;

    always_comb
    begin
        py_s  = $signed(WS'(b_py_q));
        oyq_s = $signed(WS'(b_oy_q));
        ayq_s = $signed(WS'(b_ay_q));
        oy_s  = b_oy_neg ? -oyq_s : oyq_s;
        px_s  = $signed(WS'(b_uvs[UVS_W-1 -: FRM_W]));
        ox_s  = $signed(WS'(origin_x_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            d_vld_reg <= b_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_uvs_reg <= b_uvs;
            d_ax_reg  <= WS'($signed(right_dx_reg));
            // axis y flips with the top-down frame
            d_ay_reg  <= b_ry_neg ? ayq_s : -ayq_s;
            d_dx_reg  <= px_s - ox_s;
            d_dy_reg  <= py_s - oy_s;
        end
    end

    // products
    logic                   p_vld_reg;
    logic [UVS_W-1:0]       p_uvs_reg;
    logic signed [PR_W-1:0] p_xx_reg;
    logic signed [PR_W-1:0] p_yy_reg;
    logic signed [PR_W-1:0] p_xdy_reg;
    logic signed [PR_W-1:0] p_ydx_reg;
    logic signed [PR_W-1:0] p_aa_reg;
    logic signed [PR_W-1:0] p_bb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_uvs_reg <= d_uvs_reg;
            p_xx_reg  <= PR_W'(d_ax_reg) * PR_W'(d_dx_reg);
            p_yy_reg  <= PR_W'(d_ay_reg) * PR_W'(d_dy_reg);
            p_xdy_reg <= PR_W'(d_ax_reg) * PR_W'(d_dy_reg);
            p_ydx_reg <= PR_W'(d_ay_reg) * PR_W'(d_dx_reg);
            p_aa_reg  <= PR_W'(d_ax_reg) * PR_W'(d_ax_reg);
            p_bb_reg  <= PR_W'(d_ay_reg) * PR_W'(d_ay_reg);
        end
    end

    // dot, cross and squared length
    logic signed [SUM_W-1:0] na;
    logic signed [SUM_W-1:0] nb;
    logic signed [SUM_W-1:0] dn;
    logic                    na_neg;
    logic                    nb_neg;
    logic                    s_vld_reg;
    logic [CS_W-1:0]         s_side_reg;
    logic [SUM_W-1:0]        s_na_reg;
    logic [SUM_W-1:0]        s_nb_reg;
    logic [SUM_W-1:0]        s_dn_reg;

    always_comb
    begin
        na     = SUM_W'(p_xx_reg) + SUM_W'(p_yy_reg);
        nb     = SUM_W'(p_xdy_reg) - SUM_W'(p_ydx_reg);
        dn     = SUM_W'(p_aa_reg) + SUM_W'(p_bb_reg);
        na_neg = na < 0;
        nb_neg = nb < 0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_side_reg <= {p_uvs_reg, na_neg, nb_neg, dn == '0};
            s_na_reg   <= na_neg ? SUM_W'(-na) : SUM_W'(na);
            s_nb_reg   <= nb_neg ? SUM_W'(-nb) : SUM_W'(nb);
            s_dn_reg   <= SUM_W'(dn);
        end
    end

    // projection quotients
    logic                c_vld;
    logic [CS_W-1:0]     c_side;
    logic [QD_QUO_W-1:0] cx_q;
    logic [QD_QUO_W-1:0] cy_q;
    logic                cx_ovf;
    logic                cy_ovf;

    p2a_div #(
        .NUM_W (QD_NUM_W),
        .DEN_W (SUM_W),
        .QUO_W (QD_QUO_W),
        .SIDE_W(CS_W)
    ) u_div_px (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s_vld_reg),
        .num     ({s_na_reg, {FRAC_BITS{1'b0}}}),
        .den     (s_dn_reg),
        .side_in (s_side_reg),
        .out_vld (c_vld),
        .quo     (cx_q),
        .ovf     (cx_ovf),
        .side_out(c_side)
    );

    p2a_div #(
        .NUM_W (QD_NUM_W),
        .DEN_W (SUM_W),
        .QUO_W (QD_QUO_W),
        .SIDE_W(1)
    ) u_div_py2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s_vld_reg),
        .num     ({s_nb_reg, {FRAC_BITS{1'b0}}}),
        .den     (s_dn_reg),
        .side_in (1'b0),
        .out_vld (),
        .quo     (cy_q),
        .ovf     (cy_ovf),
        .side_out()
    );

    // saturate, sign and select
    logic [FRM_W-1:0]    c_u;
    logic [FRM_W-1:0]    c_v;
    logic                c_sat;
    logic                c_xneg;
    logic                c_yneg;
    logic                c_zero;
    logic [QD_QUO_W-1:0] x_lim;
    logic [QD_QUO_W-1:0] y_lim;
    logic                x_big;
    logic                y_big;
    logic [QD_QUO_W-1:0] x_mag;
    logic [QD_QUO_W-1:0] y_mag;
    logic [POS_W-1:0]    x_pos;
    logic [POS_W-1:0]    y_pos;
    logic [POS_W-1:0]    pos_x_next;
    logic [POS_W-1:0]    pos_y_next;
    logic                applied_next;
    logic [1:0]          status_next;

    logic             out_vld_reg;
    logic [FRM_W-1:0] u_reg;
    logic [FRM_W-1:0] v_reg;
    logic [POS_W-1:0] pos_x_reg;
    logic [POS_W-1:0] pos_y_reg;
    logic             applied_reg;
    logic [1:0]       status_reg;

    always_comb
    begin
        {c_u, c_v, c_sat, c_xneg, c_yneg, c_zero} = c_side;
        x_lim = c_xneg ? LIM_NEG : LIM_POS;
        y_lim = c_yneg ? LIM_NEG : LIM_POS;
        x_big = cx_ovf || (cx_q > x_lim);
        y_big = cy_ovf || (cy_q > y_lim);
        x_mag = x_big ? x_lim : cx_q;
        y_mag = y_big ? y_lim : cy_q;
        x_pos = c_xneg ? (-x_mag[POS_W-1:0]) : x_mag[POS_W-1:0];
        y_pos = c_yneg ? (-y_mag[POS_W-1:0]) : y_mag[POS_W-1:0];

        if (!axes_ready_reg)
        begin
            pos_x_next   = POS_W'(c_u);
            pos_y_next   = POS_W'(ONE_Q - c_v);
            applied_next = 1'b0;
            status_next  = c_sat ? p2a_pkg::ST_SAT : p2a_pkg::ST_OK;
        end
        else if (c_zero)
        begin
            pos_x_next   = '0;
            pos_y_next   = '0;
            applied_next = 1'b0;
            status_next  = p2a_pkg::ST_ZERO_AXIS;
        end
        else
        begin
            pos_x_next   = x_pos;
            pos_y_next   = y_pos;
            applied_next = 1'b1;
            status_next  = (c_sat || x_big || y_big) ? p2a_pkg::ST_SAT : p2a_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= c_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg       <= c_u;
            v_reg       <= c_v;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            applied_reg <= applied_next;
            status_reg  <= status_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign frame_u      = u_reg;
    assign frame_v      = v_reg;
    assign axis_pos_x   = $signed(pos_x_reg);
    assign axis_pos_y   = $signed(pos_y_reg);
    assign axis_applied = applied_reg;
    assign status       = status_reg;

    `P2A_ASSERT_NOW(a_zero_axis_clear,
        out_vld_reg && (status_reg == p2a_pkg::ST_ZERO_AXIS),
        !applied_reg && (pos_x_reg == '0) && (pos_y_reg == '0),
        "zero-length axis result carries a coordinate")
    `P2A_ASSERT_NOW(a_plain_passes_u,
        out_vld_reg && !applied_reg && (status_reg != p2a_pkg::ST_ZERO_AXIS),
        pos_x_reg == POS_W'(u_reg),
        "untransformed result does not match frame_u")
    `P2A_ASSERT_NOW(a_ok_in_range,
        out_vld_reg && (status_reg == p2a_pkg::ST_OK),
        (u_reg <= ONE_Q) && (v_reg <= ONE_Q),
        "unsaturated result has frame coordinate above one")
    `P2A_ASSERT_NEXT(a_drain,
        out_vld_reg && out_ready && !c_vld,
        !out_vld_reg,
        "output transfer repeated")

endmodule

`default_nettype wire

// File: tb/sv/pixel_to_axis_frame_transform_tb.sv
// self-checking testbench for the pixel to user-axis frame transform
`default_nettype none

module pixel_to_axis_frame_transform_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
    } pixel_t;

    typedef struct packed {
        logic [16:0] u;
        logic [16:0] v;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic        applied;
        logic [1:0]  status;
    } transform_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        out_valid;
    logic        out_ready;
    logic [16:0] frame_u;
    logic [16:0] frame_v;
    logic signed [31:0] axis_pos_x;
    logic signed [31:0] axis_pos_y;
    logic        axis_applied;
    logic [1:0]  status;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [17:0] cfg_wdata;

    logic [12:0] shadow_width;
    logic [12:0] shadow_height;
    logic        shadow_axes;
    logic [16:0] shadow_origin_x;
    logic [16:0] shadow_origin_y;
    logic [17:0] shadow_dx;
    logic [17:0] shadow_dy;

    pixel_t     pending_pixels[$];
    transform_t expected_results[$];
    int         error_count;
    int         cycle_count;
    bit         in_taken;
    int         burst_left;
    int         gap_left;
    int         stall_mode;
    int         stall_left;

    pixel_to_axis_frame_transform dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .frame_u(frame_u),
        .frame_v(frame_v),
        .axis_pos_x(axis_pos_x),
        .axis_pos_y(axis_pos_y),
        .axis_applied(axis_applied),
        .status(status),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint scale_by_aspect(longint val, longint h, longint w);
        longint mag;
        longint q;
        mag = (val < 0) ? -val : val;
        q = mag * h / w;
        return (val < 0) ? -q : q;
    endfunction

    function automatic logic [31:0] axis_quotient(logic signed [159:0] num,
                                                  logic signed [159:0] den,
                                                  inout logic sat);
        logic         neg;
        logic [159:0] mag;
        logic [159:0] q;
        logic [159:0] lim;
        neg = (num < 0);
        mag = neg ? -num : num;
        q = (mag << 16) / den;
        lim = neg ? 160'h8000_0000 : 160'h7fff_ffff;
        if (q > lim)
        begin
            q = lim;
            sat = 1'b1;
        end
        return neg ? (~q[31:0] + 32'd1) : q[31:0];
    endfunction

    function automatic transform_t predict_transform(pixel_t p);
        transform_t r;
        longint w, h, u, v, px, py, ox, oy, ax, ay, dx, dy;
        logic signed [159:0] den, na, nb;
        logic sat;
        w = (shadow_width == 0) ? 1 : longint'(shadow_width);
        h = (shadow_height == 0) ? 1 : longint'(shadow_height);
        sat = 1'b0;
        u = (longint'(p.x) << 16) / w;
        if (u > 65536)
        begin
            u = 65536;
            sat = 1'b1;
        end
        v = (longint'(p.y) << 16) / h;
        if (v > 65536)
        begin
            v = 65536;
            sat = 1'b1;
        end
        r.u = u[16:0];
        r.v = v[16:0];
        if (!shadow_axes)
        begin
            r.pos_x = u[31:0];
            r.pos_y = 32'(65536 - v);
            r.applied = 1'b0;
            r.status = sat ? p2a_pkg::ST_SAT : p2a_pkg::ST_OK;
        end
        else
        begin
            px = u;
            py = scale_by_aspect(65536 - v, h, w);
            ox = longint'(shadow_origin_x);
            oy = scale_by_aspect(65536 - longint'(shadow_origin_y), h, w);
            ax = longint'($signed(shadow_dx));
            ay = -scale_by_aspect(longint'($signed(shadow_dy)), h, w);
            dx = px - ox;
            dy = py - oy;
            den = 160'(ax) * 160'(ax) + 160'(ay) * 160'(ay);
            if (den == 0)
            begin
                r.pos_x = '0;
                r.pos_y = '0;
                r.applied = 1'b0;
                r.status = p2a_pkg::ST_ZERO_AXIS;
            end
            else
            begin
                na = 160'(ax) * 160'(dx) + 160'(ay) * 160'(dy);
                nb = 160'(ax) * 160'(dy) - 160'(ay) * 160'(dx);
                r.pos_x = axis_quotient(na, den, sat);
                r.pos_y = axis_quotient(nb, den, sat);
                r.applied = 1'b1;
                r.status = sat ? p2a_pkg::ST_SAT : p2a_pkg::ST_OK;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", field, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        transform_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            if (!rst_n)
            begin
                shadow_width = 13'(p2a_pkg::FRAME_WIDTH_RST);
                shadow_height = 13'(p2a_pkg::FRAME_HEIGHT_RST);
                shadow_axes = 1'b0;
                shadow_origin_x = '0;
                shadow_origin_y = '0;
                shadow_dx = 18'h10000;
                shadow_dy = '0;
            end
            else if (cfg_we)
            begin
                case (cfg_index)
                    p2a_pkg::REG_FRAME_WIDTH:  shadow_width = cfg_wdata[12:0];
                    p2a_pkg::REG_FRAME_HEIGHT: shadow_height = cfg_wdata[12:0];
                    p2a_pkg::REG_AXES_READY:   shadow_axes = cfg_wdata[0];
                    p2a_pkg::REG_ORIGIN_X:     shadow_origin_x = cfg_wdata[16:0];
                    p2a_pkg::REG_ORIGIN_Y:     shadow_origin_y = cfg_wdata[16:0];
                    p2a_pkg::REG_RIGHT_DX:     shadow_dx = cfg_wdata;
                    p2a_pkg::REG_RIGHT_DY:     shadow_dy = cfg_wdata;
                    default: ;
                endcase
            end
            in_taken = rst_n && in_valid && in_ready;
            if (in_taken)
                expected_results.push_back(predict_transform({pixel_x, pixel_y}));
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected transfer", 32'd1, 32'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (frame_u !== want.u)
                        report_mismatch("frame_u", 32'(frame_u), 32'(want.u));
                    if (frame_v !== want.v)
                        report_mismatch("frame_v", 32'(frame_v), 32'(want.v));
                    if (axis_pos_x !== want.pos_x)
                        report_mismatch("axis_pos_x", axis_pos_x, want.pos_x);
                    if (axis_pos_y !== want.pos_y)
                        report_mismatch("axis_pos_y", axis_pos_y, want.pos_y);
                    if (axis_applied !== want.applied)
                        report_mismatch("axis_applied", 32'(axis_applied), 32'(want.applied));
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                end
            end
        end
    end

    // sender bursts
    always @(negedge clk)
    begin
        pixel_t p;
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_pixels.size() > 0)
            begin
                p = pending_pixels.pop_front();
                in_valid <= 1'b1;
                pixel_x <= p.x;
                pixel_y <= p.y;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (stall_left <= 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 120);
        end
        stall_left--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic write_reg(logic [2:0] idx, logic [17:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic queue_pixel(int x, int y);
        pending_pixels.push_back({12'(x), 12'(y)});
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [17:0] random_vector();
        case ($urandom_range(0, 6))
            0: return 18'h10000;
            1: return 18'h30000;
            2: return 18'h0;
            3: return 18'($urandom);
            default: return 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic logic [17:0] random_dim();
        case ($urandom_range(0, 7))
            0: return 18'($urandom_range(0, 8191));
            1: return 18'd1;
            2: return 18'd4096;
            default: return 18'($urandom_range(1, 4096));
        endcase
    endfunction

    task automatic queue_random_pixels(int count);
        int xmax, ymax;
        for (int i = 0; i < count; i++)
        begin
            xmax = (shadow_width + 2 > 4095) ? 4095 : shadow_width + 2;
            ymax = (shadow_height + 2 > 4095) ? 4095 : shadow_height + 2;
            if ($urandom_range(0, 3) == 0)
                queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
            else
                queue_pixel($urandom_range(0, xmax), $urandom_range(0, ymax));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel_x = '0;
        pixel_y = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        error_count = 0;
        cycle_count = 0;
        in_taken = 0;
        burst_left = 1;
        gap_left = 0;
        stall_mode = 0;
        stall_left = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults, no axes
        queue_pixel(0, 0);
        queue_pixel(4095, 4095);
        queue_pixel(640, 480);
        queue_pixel(641, 479);
        queue_pixel(2730, 1365);
        queue_pixel(320, 240);
        drain();

        // default axis applied, origin at corner
        write_reg(p2a_pkg::REG_AXES_READY, 18'd1);
        end_writes();
        queue_pixel(0, 0);
        queue_pixel(640, 480);
        queue_pixel(4095, 0);
        queue_pixel(0, 4095);
        drain();

        // tiny axis and narrow frame: overflow, aspect truncation to zero axis
        write_reg(p2a_pkg::REG_FRAME_WIDTH, 18'd4096);
        write_reg(p2a_pkg::REG_FRAME_HEIGHT, 18'd1);
        write_reg(p2a_pkg::REG_ORIGIN_X, 18'h1ffff);
        write_reg(p2a_pkg::REG_ORIGIN_Y, 18'h1ffff);
        write_reg(p2a_pkg::REG_RIGHT_DX, 18'd1);
        write_reg(p2a_pkg::REG_RIGHT_DY, 18'd0);
        end_writes();
        queue_pixel(4095, 4095);
        queue_pixel(0, 0);
        queue_pixel(2048, 1);
        drain();
        write_reg(p2a_pkg::REG_RIGHT_DX, 18'd0);
        write_reg(p2a_pkg::REG_RIGHT_DY, 18'd1);
        end_writes();
        queue_pixel(100, 0);
        queue_pixel(4095, 4095);
        drain();

        // zero frame size, negative axis
        write_reg(p2a_pkg::REG_FRAME_WIDTH, 18'd0);
        write_reg(p2a_pkg::REG_FRAME_HEIGHT, 18'd0);
        write_reg(p2a_pkg::REG_ORIGIN_X, 18'd0);
        write_reg(p2a_pkg::REG_ORIGIN_Y, 18'd65536);
        write_reg(p2a_pkg::REG_RIGHT_DX, 18'h30000);
        write_reg(p2a_pkg::REG_RIGHT_DY, 18'h30000);
        end_writes();
        queue_pixel(0, 0);
        queue_pixel(1, 1);
        queue_pixel(4095, 4095);
        drain();

        for (int phase = 0; phase < 11; phase++)
        begin
            write_reg(p2a_pkg::REG_FRAME_WIDTH, random_dim());
            write_reg(p2a_pkg::REG_FRAME_HEIGHT, random_dim());
            write_reg(p2a_pkg::REG_AXES_READY, 18'($urandom_range(0, 4) != 0));
            write_reg(p2a_pkg::REG_ORIGIN_X, ($urandom_range(0, 5) == 0) ? 18'($urandom)
                                                               : 18'($urandom_range(0, 65536)));
            write_reg(p2a_pkg::REG_ORIGIN_Y, ($urandom_range(0, 5) == 0) ? 18'($urandom)
                                                               : 18'($urandom_range(0, 65536)));
            write_reg(p2a_pkg::REG_RIGHT_DX, random_vector());
            write_reg(p2a_pkg::REG_RIGHT_DY, random_vector());
            end_writes();
            queue_random_pixels(64);
            drain();
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/p2a_pkg.sv
rtl/core/p2a_div.sv
rtl/core/pixel_to_axis_frame_transform.sv
tb/sv/pixel_to_axis_frame_transform_tb.sv
